@@ rtl/riff_chunk_scanner_macros.svh @@
`ifndef RIFF_CHUNK_SCANNER_MACROS_SVH
`define RIFF_CHUNK_SCANNER_MACROS_SVH

// same-cycle implication, clocked on clk and held off while rst_n is low
`define RCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rcs_pkg.sv @@
package rcs_pkg;

  localparam int unsigned POS_W      = 33;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned SIZE_W     = 32;
  localparam int unsigned OUT_DATA_W = 104;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;

  localparam int unsigned HDR_BYTES       = 8;
  localparam int unsigned RIFF_TAG_LAST   = 3;
  localparam int unsigned MASTER_HDR_LAST = 11;
  localparam int unsigned FIRST_CHUNK_OFF = 12;

  typedef enum logic {
    KIND_CHUNK  = 1'b0,
    KIND_REJECT = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    kind_t              result_kind;
    logic [ID_W-1:0]    chunk_id;
    logic [SIZE_W-1:0]  chunk_size;
    logic [POS_W-1:0]   data_offset;
  } res_t;

endpackage

@@ rtl/rcs_scan_core.sv @@
module rcs_scan_core #(
  parameter int unsigned CHUNK_ALIGN = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  rcs_pkg::item_t            item,
  input  logic [rcs_pkg::POS_W-1:0] data_length,
  output logic                      res_valid,
  output rcs_pkg::res_t             res
);

  localparam int unsigned REM_W = (CHUNK_ALIGN > 1) ? $clog2(CHUNK_ALIGN) : 1;
  localparam int unsigned PAD_W = $clog2(CHUNK_ALIGN + 1);
  localparam int unsigned W1 = 256 % CHUNK_ALIGN;
  localparam int unsigned W2 = 65536 % CHUNK_ALIGN;
  localparam int unsigned W3 = 16777216 % CHUNK_ALIGN;
  localparam int unsigned HDR_BYTES_I = rcs_pkg::HDR_BYTES;
  // header offset mod align is 12 mod align for the first chunk, else zero
  localparam int unsigned BASE_FIRST = (HDR_BYTES_I + 12) % CHUNK_ALIGN;
  localparam int unsigned BASE_NEXT  = HDR_BYTES_I % CHUNK_ALIGN;

  typedef logic [REM_W-1:0] rem_tab_t [256];

  // (i * wt) mod align for every byte value
  function automatic rem_tab_t build_tab(input int unsigned wt);
    rem_tab_t tab;
    for (int unsigned i = 0; i < 256; i++) begin
      tab[i] = REM_W'((i * wt) % CHUNK_ALIGN);
    end
    return tab;
  endfunction

  localparam rem_tab_t TAB0 = build_tab(1);
  localparam rem_tab_t TAB1 = build_tab(W1);
  localparam rem_tab_t TAB2 = build_tab(W2);
  localparam rem_tab_t TAB3 = build_tab(W3);

  logic [32:0] pos_r, pos_nxt, bound_r, bound_nxt, nho_r, nho_nxt;
  logic [63:0] shift_r, shift_nxt;
  logic        riff_r, riff_nxt, wave_r, wave_nxt;

  logic [32:0] pos_cur, bound_cur, nho_cur;
  logic [63:0] shift_cur, shift_new;
  logic        riff_cur, wave_cur;

  logic        hdr_hit;
  logic [33:0] doff;
  logic [34:0] chunk_end, clamp_end, end_align;
  logic [32:0] declared;
  logic [7:0]  rem_sum;
  logic [REM_W-1:0] rem;
  logic [PAD_W-1:0] pad;
  logic [31:0] csize;
  logic [32:0] next_off;

  always_comb begin
    // a start-of-file word restarts the scan before it is counted
    pos_cur   = item.first_byte ? '0 : pos_r;
    shift_cur = item.first_byte ? '0 : shift_r;
    riff_cur  = item.first_byte ? 1'b0 : riff_r;
    bound_cur = item.first_byte ? '0 : bound_r;
    wave_cur  = item.first_byte ? 1'b0 : wave_r;
    nho_cur   = item.first_byte ? 33'(rcs_pkg::FIRST_CHUNK_OFF) : nho_r;

    shift_new = {item.data_byte, shift_cur[63:8]};

    hdr_hit = (nho_cur < bound_cur)
           && ({1'b0, nho_cur} + 34'(rcs_pkg::HDR_BYTES) <= {1'b0, data_length})
           && ({1'b0, pos_cur} == {1'b0, nho_cur} + 34'(rcs_pkg::HDR_BYTES - 1));

    doff      = {1'b0, nho_cur} + 34'(rcs_pkg::HDR_BYTES);
    chunk_end = {1'b0, doff} + 35'(shift_new[63:32]);
    clamp_end = (chunk_end < {2'b0, bound_cur}) ? chunk_end : {2'b0, bound_cur};
    csize     = (clamp_end > {1'b0, doff}) ? 32'(clamp_end - {1'b0, doff}) : '0;

    // chunk end mod align from per-byte residues of the size field
    rem_sum = 8'(TAB0[shift_new[39:32]]) + 8'(TAB1[shift_new[47:40]])
            + 8'(TAB2[shift_new[55:48]]) + 8'(TAB3[shift_new[63:56]])
            + ((nho_cur == 33'(rcs_pkg::FIRST_CHUNK_OFF)) ? 8'(BASE_FIRST)
                                                          : 8'(BASE_NEXT));
    rem = TAB0[rem_sum];
    pad = (rem == '0) ? '0 : (PAD_W'(CHUNK_ALIGN) - PAD_W'(rem));
    end_align = chunk_end + 35'(pad);
    next_off  = (end_align > 35'(rcs_pkg::POS_MAX)) ? rcs_pkg::POS_MAX : end_align[32:0];

    declared = 33'(shift_new[31:0]) + 33'(rcs_pkg::HDR_BYTES);

    pos_nxt   = (pos_cur == rcs_pkg::POS_MAX) ? pos_cur : pos_cur + 33'd1;
    shift_nxt = shift_cur;
    riff_nxt  = riff_cur;
    bound_nxt = bound_cur;
    wave_nxt  = wave_cur;
    nho_nxt   = nho_cur;
    res_valid = 1'b0;
    res.result_kind = rcs_pkg::KIND_CHUNK;
    res.chunk_id    = '0;
    res.chunk_size  = '0;
    res.data_offset = '0;

    if (pos_cur < data_length) begin
      shift_nxt = shift_new;
      if (data_length < 33'(rcs_pkg::FIRST_CHUNK_OFF)) begin
        if (pos_cur == data_length - 33'd1) begin
          res_valid       = 1'b1;
          res.result_kind = rcs_pkg::KIND_REJECT;
        end
      end else if (pos_cur == 33'(rcs_pkg::RIFF_TAG_LAST)) begin
        riff_nxt = (shift_new[63:32] == rcs_pkg::TAG_RIFF);
      end else if (pos_cur == 33'(rcs_pkg::MASTER_HDR_LAST)) begin
        if (riff_cur && (shift_new[63:32] == rcs_pkg::TAG_WAVE)) begin
          wave_nxt  = 1'b1;
          bound_nxt = (declared < data_length) ? declared : data_length;
          nho_nxt   = 33'(rcs_pkg::FIRST_CHUNK_OFF);
        end else begin
          wave_nxt        = 1'b0;
          res_valid       = 1'b1;
          res.result_kind = rcs_pkg::KIND_REJECT;
        end
      end else if (wave_cur && (pos_cur > 33'(rcs_pkg::MASTER_HDR_LAST)) && hdr_hit) begin
        nho_nxt         = next_off;
        res_valid       = 1'b1;
        res.chunk_id    = shift_new[31:0];
        res.chunk_size  = csize;
        res.data_offset = doff[32:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      shift_r <= '0;
      riff_r  <= 1'b0;
      bound_r <= '0;
      wave_r  <= 1'b0;
      nho_r   <= 33'(rcs_pkg::FIRST_CHUNK_OFF);
    end else if (step_en) begin
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      riff_r  <= riff_nxt;
      bound_r <= bound_nxt;
      wave_r  <= wave_nxt;
      nho_r   <= nho_nxt;
    end
  end

endmodule

@@ rtl/rcs_out_stage.sv @@
module rcs_out_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  rcs_pkg::res_t                  res_in,
  output logic                           free,
  input  logic                           out_tready,
  output logic                           out_tvalid,
  output logic [rcs_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser
);

  logic          valid_r, valid_nxt;
  rcs_pkg::res_t res_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {7'b0, res_r.data_offset, res_r.chunk_size, res_r.chunk_id};
  assign out_tuser  = res_r.result_kind;

endmodule

@@ rtl/riff_chunk_scanner.sv @@
// a word is held in the input word register; its result is then registered for out_*
// throughput: one word per cycle while out_tready stays high
// a result held by out_tready low stops the core, so in_tready drops once one more word waits
// reset (rst_n low, synchronous): data_length clears to 0, scan restarts at offset 0
// with next header offset 12, both channel registers empty
module riff_chunk_scanner #(
  parameter int unsigned CHUNK_ALIGN = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic                           in_tuser,   // [0] first_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] chunk_id, [63:32] chunk_size, [96:64] data_offset, [103:97] zero
  output logic [rcs_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser,  // [0] result_kind
  input  logic                           cfg_wr_en,
  input  logic [rcs_pkg::POS_W-1:0]      cfg_wr_data
);

  logic [rcs_pkg::POS_W-1:0] data_length_r;
  logic                      s1_valid_r, s1_valid_nxt;
  rcs_pkg::item_t            s1_item_r;
  logic                      step_en, out_free, core_res_valid;
  rcs_pkg::res_t             core_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_length_r <= '0;
    end else if (cfg_wr_en) begin
      data_length_r <= cfg_wr_data;
    end
  end

  assign step_en   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || step_en;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (step_en) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.data_byte  <= in_tdata;
      s1_item_r.first_byte <= in_tuser;
    end
  end

  rcs_scan_core #(
    .CHUNK_ALIGN (CHUNK_ALIGN)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .item        (s1_item_r),
    .data_length (data_length_r),
    .res_valid   (core_res_valid),
    .res         (core_res)
  );

  rcs_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_en && core_res_valid),
    .res_in     (core_res),
    .free       (out_free),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`include "riff_chunk_scanner_macros.svh"

  `RCS_ASSERT_NOW(a_reject_zero, out_tvalid && out_tuser, out_tdata == '0, "reject word has payload")
  `RCS_ASSERT_NOW(a_chunk_off, out_tvalid && !out_tuser, out_tdata[96:64] >= 33'd20, "chunk offset below 20")
  `RCS_ASSERT_NOW(a_rose_step, $rose(out_tvalid), $past(step_en), "result without core step")
  `RCS_ASSERT_NEXT(a_load_shows, step_en && core_res_valid, out_tvalid, "loaded result not shown")

endmodule

@@ verif/riff_chunk_scanner_test.sv @@
module riff_chunk_scanner_test;

  localparam int unsigned POS_W           = rcs_pkg::POS_W;
  localparam int unsigned OUT_W           = rcs_pkg::OUT_DATA_W;
  localparam int unsigned CHUNK_ALIGN     = 2;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned RANDOM_WORDS    = 900;
  localparam int unsigned SETTLE_CYCLES   = 4;

  typedef enum int unsigned {
    MARK_FIRST,
    MARK_NONE,
    MARK_RANDOM
  } mark_mode_t;

  class chunk_scoreboard;
    logic [POS_W-1:0]  buf_len;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  bound;
    logic [POS_W-1:0]  next_hdr;
    logic [63:0]       last_bytes;
    bit                riff_ok;
    bit                wave_ok;
    rcs_pkg::res_t     expected_q[$];
    int unsigned       words_in;
    int unsigned       chunks_seen;
    int unsigned       rejects_seen;
    int unsigned       mismatches;

    function new();
      buf_len = '0;
      words_in = 0;
      chunks_seen = 0;
      rejects_seen = 0;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      pos = '0;
      last_bytes = '0;
      riff_ok = 1'b0;
      bound = '0;
      wave_ok = 1'b0;
      next_hdr = POS_W'(rcs_pkg::FIRST_CHUNK_OFF);
    endfunction

    function void push_reject();
      rcs_pkg::res_t r;
      r.result_kind = rcs_pkg::KIND_REJECT;
      r.chunk_id = '0;
      r.chunk_size = '0;
      r.data_offset = '0;
      expected_q.push_back(r);
    endfunction

    // one accepted input word: advance the scan and queue any result it causes
    function void note_word(logic [7:0] b, logic first);
      logic [POS_W-1:0] p;
      logic [63:0]      off;
      logic [63:0]      doff;
      logic [63:0]      fin;
      logic [63:0]      cend;
      logic [63:0]      nxt;
      logic [63:0]      declared;
      rcs_pkg::res_t    r;
      words_in++;
      if (first) restart();
      p = pos;
      if (pos != rcs_pkg::POS_MAX) pos = pos + POS_W'(1);
      if (p >= buf_len) return;
      last_bytes = {b, last_bytes[63:8]};
      if (buf_len < POS_W'(rcs_pkg::FIRST_CHUNK_OFF)) begin
        if (p == buf_len - POS_W'(1)) push_reject();
        return;
      end
      if (p == POS_W'(rcs_pkg::RIFF_TAG_LAST)) begin
        riff_ok = (last_bytes[63:32] == rcs_pkg::TAG_RIFF);
      end else if (p == POS_W'(rcs_pkg::MASTER_HDR_LAST)) begin
        if (riff_ok && last_bytes[63:32] == rcs_pkg::TAG_WAVE) begin
          declared = {32'd0, last_bytes[31:0]} + 64'(rcs_pkg::HDR_BYTES);
          wave_ok = 1'b1;
          bound = (declared < {31'd0, buf_len}) ? declared[POS_W-1:0] : buf_len;
          next_hdr = POS_W'(rcs_pkg::FIRST_CHUNK_OFF);
        end else begin
          wave_ok = 1'b0;
          push_reject();
        end
      end else if (wave_ok && p > POS_W'(rcs_pkg::MASTER_HDR_LAST)) begin
        off = {31'd0, next_hdr};
        if (off < {31'd0, bound} && off + 64'(rcs_pkg::HDR_BYTES) <= {31'd0, buf_len} &&
            {31'd0, p} == off + 64'(rcs_pkg::HDR_BYTES - 1)) begin
          doff = off + 64'(rcs_pkg::HDR_BYTES);
          fin = doff + {32'd0, last_bytes[63:32]};
          // data may not run past the bound; a header straddling it gives size 0
          cend = (fin < {31'd0, bound}) ? fin : {31'd0, bound};
          r.result_kind = rcs_pkg::KIND_CHUNK;
          r.chunk_id = last_bytes[31:0];
          r.chunk_size = (cend > doff) ? 32'(cend - doff) : '0;
          r.data_offset = doff[POS_W-1:0];
          // next header follows the unclamped end, aligned up
          nxt = ((fin + 64'(CHUNK_ALIGN - 1)) / 64'(CHUNK_ALIGN)) * 64'(CHUNK_ALIGN);
          next_hdr = (nxt > {31'd0, rcs_pkg::POS_MAX}) ? rcs_pkg::POS_MAX : nxt[POS_W-1:0];
          expected_q.push_back(r);
        end
      end
    endfunction

    function void check_word(logic [OUT_W-1:0] data, logic kind);
      rcs_pkg::res_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d id %h size %h offset %h",
                   kind, data[31:0], data[63:32], data[96:64]);
        return;
      end
      want = expected_q.pop_front();
      if (kind == rcs_pkg::KIND_REJECT) rejects_seen++;
      else chunks_seen++;
      if (kind !== want.result_kind || data[31:0] !== want.chunk_id ||
          data[63:32] !== want.chunk_size || data[96:64] !== want.data_offset) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp kind %0d id %h size %h offset %h,",
                    " got kind %0d id %h size %h offset %h"},
                   want.result_kind, want.chunk_id, want.chunk_size, want.data_offset,
                   kind, data[31:0], data[63:32], data[96:64]);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tuser;
  logic              cfg_wr_en = 1'b0;
  logic [POS_W-1:0]  cfg_wr_data = '0;

  chunk_scoreboard sb = new();
  logic [7:0]      file_q[$];
  bit              tx_gaps = 1'b0;
  bit              rx_gaps = 1'b0;
  bit              stall_request = 1'b0;
  int unsigned     quiet_cycles = 0;
  int unsigned     length_writes = 0;

  riff_chunk_scanner #(.CHUNK_ALIGN(CHUNK_ALIGN)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_word(in_tdata, in_tuser);
      if (out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", quiet_cycles);
      $display("riff_chunk_scanner_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_tready <= rst_n && !(rx_gaps && $urandom_range(99) < 13);
    end
  end

  task automatic send_word(input logic [7:0] b, input logic first);
    while (tx_gaps && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= first;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering words and let every pending result drain out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [POS_W-1:0] len);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.buf_len = len;
    length_writes++;
  endtask

  task automatic push_le32(input logic [31:0] w);
    for (int k = 0; k < 4; k++) file_q.push_back(w[8*k +: 8]);
  endtask

  task automatic send_file(input mark_mode_t mode, input int unsigned split_at,
                           input logic [POS_W-1:0] split_len);
    logic first;
    for (int i = 0; i < file_q.size(); i++) begin
      if (split_at != 0 && i == split_at) begin
        drain();
        write_length(split_len);
      end
      case (mode)
        MARK_FIRST:  first = (i == 0);
        MARK_NONE:   first = 1'b0;
        default:     first = ($urandom_range(7) == 0);
      endcase
      send_word(file_q[i], first);
    end
  endtask

  task automatic build_wave_file(output logic [POS_W-1:0] len);
    int unsigned nchunks;
    int unsigned body;
    int unsigned idx;
    logic [31:0] sz;
    logic [31:0] declared;
    file_q.delete();
    push_le32(rcs_pkg::TAG_RIFF);
    push_le32(32'd0);
    push_le32(rcs_pkg::TAG_WAVE);
    nchunks = $urandom_range(5, 1);
    for (int c = 0; c < nchunks; c++) begin
      push_le32($urandom());
      case ($urandom_range(19))
        0:       sz = 32'hFFFF_FFFF;
        1:       sz = $urandom();
        default: sz = $urandom_range(24);
      endcase
      push_le32(sz);
      if (sz > 40) body = $urandom_range(6);
      else body = sz + ((sz % CHUNK_ALIGN) != 0 ? CHUNK_ALIGN - sz % CHUNK_ALIGN : 0);
      repeat (body) file_q.push_back(8'($urandom()));
    end
    body = file_q.size() - rcs_pkg::HDR_BYTES;
    case ($urandom_range(9))
      0:       declared = body - $urandom_range(12, 1);  // bound lands inside the file
      1:       declared = body + $urandom_range(30);
      2:       declared = $urandom();
      3:       declared = 32'hFFFF_FFFF;
      default: declared = body;
    endcase
    for (int k = 0; k < 4; k++) file_q[4 + k] = declared[8*k +: 8];
    // damage one tag bit now and then
    if ($urandom_range(7) == 0) begin
      idx = $urandom_range(3) + ($urandom_range(1) ? rcs_pkg::MASTER_HDR_LAST - 3 : 0);
      file_q[idx] = file_q[idx] ^ (8'h01 << $urandom_range(7));
    end
    case ($urandom_range(9))
      0:       len = POS_W'($urandom_range(file_q.size()));
      1:       len = POS_W'(file_q.size() + $urandom_range(16));
      2:       len = rcs_pkg::POS_MAX;
      default: len = POS_W'(file_q.size());
    endcase
  endtask

  task automatic build_noise(output logic [POS_W-1:0] len);
    file_q.delete();
    repeat ($urandom_range(30, 1)) file_q.push_back(8'($urandom()));
    case ($urandom_range(2))
      0:       len = POS_W'($urandom_range(15));
      1:       len = rcs_pkg::POS_MAX;
      default: len = POS_W'(file_q.size());
    endcase
  endtask

  initial begin : stimulus
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] split_len;
    int unsigned      pick;
    int unsigned      split_at;
    int unsigned      file_no;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // length 0 after reset: every word is past the buffer
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h5A, 1'b1);
    drain();

    // short buffer: reject on its last byte, then one word beyond it
    write_length(33'd5);
    file_q.delete();
    push_le32(rcs_pkg::TAG_RIFF);
    file_q.push_back(8'hFF);
    file_q.push_back(8'h00);
    send_file(MARK_FIRST, 0, '0);
    drain();

    // full master header with a wrong form tag
    write_length(33'd12);
    file_q.delete();
    push_le32(rcs_pkg::TAG_RIFF);
    push_le32(32'h0000_0004);
    push_le32(rcs_pkg::TAG_WAVE ^ 32'h0100_0000);
    send_file(MARK_FIRST, 0, '0);
    drain();

    file_no = 0;
    while (sb.words_in < RANDOM_WORDS) begin
      // first few files run with no gaps on either side
      tx_gaps = (file_no > 2) && ($urandom_range(4) != 0);
      rx_gaps = (file_no > 2) && ($urandom_range(4) != 0);
      pick = $urandom_range(9);
      split_at = 0;
      split_len = '0;
      if (file_no == 6) begin
        build_wave_file(len);
        while (file_q.size() < 60) file_q.push_back(8'($urandom()));
        write_length(POS_W'(file_q.size()));
        stall_request = 1'b1;
        send_file(MARK_FIRST, 0, '0);
      end else if (pick == 9) begin
        build_noise(len);
        write_length(len);
        send_file(MARK_RANDOM, 0, '0);
      end else if (pick == 8) begin
        // carry on without a restart mark under the current length
        build_noise(len);
        send_file(MARK_NONE, 0, '0);
      end else begin
        build_wave_file(len);
        write_length(len);
        if ($urandom_range(9) == 0) begin
          split_at = $urandom_range(file_q.size() - 1, 1);
          split_len = POS_W'($urandom_range(file_q.size() + 8));
        end
        send_file(MARK_FIRST, split_at, split_len);
      end
      drain();
      file_no++;
    end

    drain();
    repeat (8) @(posedge clk);
    $display("scanned %0d words in %0d random files with %0d length settings",
             sb.words_in, file_no, length_writes);
    $display("checked %0d chunk headers and %0d rejects, %0d mismatches",
             sb.chunks_seen, sb.rejects_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("riff_chunk_scanner_test: PASS");
    end else begin
      $display("riff_chunk_scanner_test: FAIL");
    end
    $finish;
  end

endmodule
